// File: src/i2ccap_pkg.sv
// Shared types and codes for the I2C capture symbol decoder.
`default_nettype none
package i2ccap_pkg;

    localparam logic [1:0] KIND_STOP  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    localparam logic [3:0] SYM_START = 4'd1;
    localparam logic [3:0] SYM_STOP  = 4'd2;

    localparam logic [3:0] BITS_PER_SYM = 4'd3;
    localparam logic [3:0] BITS_PER_EVT = 4'd9;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [7:0] value;
        logic       read_flag;
        logic       acked;
        logic       last;
    } t_event;

    typedef struct packed {
        logic       start_pending;
        logic [3:0] bit_count;
        logic [8:0] bit_accumulator;
    } t_state;

    typedef struct packed {
        logic [1:0] count;
        t_event     ev0;
        t_event     ev1;
    } t_dec_out;

endpackage
`default_nettype wire

// File: src/i2ccap_in_if.sv
// Capture byte channel.
`default_nettype none
interface i2ccap_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] capture_byte;

    modport source (output valid, output capture_byte, input ready);
    modport sink   (input valid, input capture_byte, output ready);
endinterface
`default_nettype wire

// File: src/i2ccap_out_if.sv
// Bus event channel.
`default_nettype none
interface i2ccap_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] value;
    logic       read_flag;
    logic       acked;
    logic       last;

    modport source (output valid, output event_kind, output value, output read_flag,
                    output acked, output last, input ready);
    modport sink   (input valid, input event_kind, input value, input read_flag,
                    input acked, input last, output ready);
endinterface
`default_nettype wire

// File: src/i2ccap_decode.sv
// Two-symbol decoder with start, bit count and accumulator state.
`default_nettype none
module i2ccap_decode (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_advance,
    input  wire logic [7:0]            i_byte,
    output i2ccap_pkg::t_dec_out       o_dec
);
    import i2ccap_pkg::*;

    typedef struct packed {
        t_state st;
        logic   ev_v;
        t_event ev;
    } t_step;

    function automatic t_step do_sym(input logic [3:0] sym, input t_state st);
        t_step      r;
        logic [8:0] acc;
        logic [3:0] cnt;
        r      = '0;
        r.st   = st;
        acc    = {st.bit_accumulator[5:0], sym[2:0]};
        cnt    = st.bit_count + BITS_PER_SYM;
        if (sym == SYM_START) begin
            r.st.start_pending = 1'b1;
        end else if (sym == SYM_STOP) begin
            r.ev_v             = 1'b1;
            r.ev.event_kind    = KIND_STOP;
            r.st.start_pending = 1'b1;
        end else if (sym[3]) begin
            r.st.bit_accumulator = acc;
            r.st.bit_count       = cnt;
            if (cnt == BITS_PER_EVT) begin
                r.ev_v     = 1'b1;
                r.ev.acked = ~acc[0];
                if (st.start_pending) begin
                    r.ev.event_kind    = KIND_START;
                    r.ev.value         = {1'b0, acc[8:2]};
                    r.ev.read_flag     = acc[1];
                    r.st.start_pending = 1'b0;
                end else begin
                    r.ev.event_kind = KIND_DATA;
                    r.ev.value      = acc[8:1];
                end
                r.st.bit_count       = '0;
                r.st.bit_accumulator = '0;
            end
        end
        return r;
    endfunction

    t_state r_st;
    t_step  s_hi;
    t_step  s_lo;

    always_comb begin
        s_hi = do_sym(i_byte[7:4], r_st);
        s_lo = do_sym(i_byte[3:0], s_hi.st);
        o_dec       = '0;
        o_dec.count = {1'b0, s_hi.ev_v} + {1'b0, s_lo.ev_v};
        if (s_hi.ev_v) begin
            o_dec.ev0      = s_hi.ev;
            o_dec.ev1      = s_lo.ev;
            o_dec.ev0.last = ~s_lo.ev_v;
            o_dec.ev1.last = 1'b1;
        end else begin
            o_dec.ev0      = s_lo.ev;
            o_dec.ev0.last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_advance) begin
            r_st <= s_lo.st;
        end
    end

endmodule
`default_nettype wire

// File: src/i2ccap_event_queue.sv
// Four-entry event queue, up to two writes and one read per cycle.
`default_nettype none
module i2ccap_event_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [1:0]            i_push,
    input  wire i2ccap_pkg::t_event    i_ev0,
    input  wire i2ccap_pkg::t_event    i_ev1,
    input  wire logic                  i_pop,
    output logic                       o_room2,
    output logic                       o_valid,
    output i2ccap_pkg::t_event         o_ev
);
    import i2ccap_pkg::*;

    t_event     r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic       s_pop;

    assign o_valid = (r_count != 3'd0);
    assign o_ev    = r_mem[r_rd_ptr];
    assign o_room2 = (r_count <= 3'd2);
    assign s_pop   = i_pop && o_valid;
    assign n_count = r_count + {1'b0, i_push} - {2'b0, s_pop};

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr_ptr] <= i_ev0;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr_ptr + 2'd1] <= i_ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push;
            r_rd_ptr <= r_rd_ptr + {1'b0, s_pop};
            r_count  <= n_count;
        end
    end

endmodule
`default_nettype wire

// File: src/i2c_capture_symbol_decoder_unit.sv
// I2C capture symbol decoder, top level.
// Path: a byte is held in the input register, decoded and pushed to the event queue.
// One byte per cycle while the queue has room for two events; one event out per cycle
//   while the receiver is ready, so the two events of a byte leave one after the other.
// Reset: synchronous active low; clears start flag, bit count, accumulator and queue.
`default_nettype none
module i2c_capture_symbol_decoder_unit (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    i2ccap_in_if.sink     i_cap,
    i2ccap_out_if.source  o_evt
);
    import i2ccap_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       s_advance;
    logic       s_room2;
    logic [1:0] s_push;
    t_dec_out   s_dec;
    t_event     s_ev;

    assign s_advance   = r_in_valid && s_room2;
    assign i_cap.ready = !r_in_valid || s_room2;
    assign s_push      = s_advance ? s_dec.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cap.ready) begin
            r_in_valid <= i_cap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cap.ready && i_cap.valid) begin
            r_byte <= i_cap.capture_byte;
        end
    end

    i2ccap_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s_advance),
        .i_byte    (r_byte),
        .o_dec     (s_dec)
    );

    i2ccap_event_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_ev0   (s_dec.ev0),
        .i_ev1   (s_dec.ev1),
        .i_pop   (o_evt.ready),
        .o_room2 (s_room2),
        .o_valid (o_evt.valid),
        .o_ev    (s_ev)
    );

    assign o_evt.event_kind = s_ev.event_kind;
    assign o_evt.value      = s_ev.value;
    assign o_evt.read_flag  = s_ev.read_flag;
    assign o_evt.acked      = s_ev.acked;
    assign o_evt.last       = s_ev.last;

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Self-checking testbench for the I2C capture symbol decoder: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;
    import i2ccap_pkg::*;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         ITEMS_PHASE   = 300;
    localparam int         NUM_PHASES    = 5;
    localparam int         PREDICT       = -1;
    localparam logic [3:0] SYM_NONE      = 4'd0;
    localparam logic [3:0] SYM_NOISE_LO  = 4'd3;
    localparam logic [3:0] SYM_NOISE_HI  = 4'd7;
    localparam t_event     NO_EVENT      = '0;

    typedef struct {
        logic [7:0] cap_byte;
        int         typed_n;
        t_event     e0;
        t_event     e1;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    i2ccap_in_if  cap ();
    i2ccap_out_if evt ();

    i2c_capture_symbol_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (cap),
        .o_evt   (evt)
    );

    // decoder state mirror
    logic       armed;
    logic [3:0] nbits;
    logic [8:0] shreg;

    t_event events_due[$];
    t_row   directed_rows[$];

    int errors       = 0;
    int bytes_sent   = 0;
    int events_seen  = 0;
    int kind_seen[3] = '{0, 0, 0};
    int cycles       = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_reqs  = 0;
    int hold_taken = 0;
    int hold_left  = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_reqs != hold_taken) begin
            hold_taken = hold_reqs;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            evt.ready <= 1'b0;
        end else begin
            evt.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic t_event mk_event(logic [1:0] k, logic [7:0] v, logic rd, logic ack,
                                        logic lst);
        t_event e;
        e.event_kind = k;
        e.value      = v;
        e.read_flag  = rd;
        e.acked      = ack;
        e.last       = lst;
        return e;
    endfunction

    task automatic decode_symbol(input logic [3:0] sym, output bit fired, output t_event ev);
        fired = 1'b0;
        ev    = NO_EVENT;
        if (sym == SYM_START) begin
            armed = 1'b1;
        end else if (sym == SYM_STOP) begin
            ev.event_kind = KIND_STOP;
            fired = 1'b1;
            armed = 1'b1;
        end else if (sym[3]) begin
            shreg = {shreg[5:0], sym[2:0]};
            nbits = nbits + BITS_PER_SYM;
            if (nbits == BITS_PER_EVT) begin
                ev.acked = ~shreg[0];
                if (armed) begin
                    ev.event_kind = KIND_START;
                    ev.value      = {1'b0, shreg[8:2]};
                    ev.read_flag  = shreg[1];
                    armed = 1'b0;
                end else begin
                    ev.event_kind = KIND_DATA;
                    ev.value      = shreg[8:1];
                end
                nbits = '0;
                shreg = '0;
                fired = 1'b1;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] b, output int n, output t_event e0,
                                output t_event e1);
        bit     f_hi, f_lo;
        t_event h, l;
        decode_symbol(b[7:4], f_hi, h);
        decode_symbol(b[3:0], f_lo, l);
        n  = 0;
        e0 = NO_EVENT;
        e1 = NO_EVENT;
        if (f_hi) begin
            e0 = h;
            n  = 1;
        end
        if (f_lo) begin
            if (n == 0) e0 = l;
            else e1 = l;
            n++;
        end
        if (n == 1) e0.last = 1'b1;
        else if (n == 2) e1.last = 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input int typed_n, input t_event t0,
                             input t_event t1);
        int     n;
        t_event e0, e1;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            cap.valid <= 1'b0;
            @(posedge i_clk);
        end
        cap.valid        <= 1'b1;
        cap.capture_byte <= b;
        @(posedge i_clk);
        while (cap.ready !== 1'b1) @(posedge i_clk);
        predict_byte(b, n, e0, e1);
        if (typed_n != PREDICT) begin
            n  = typed_n;
            e0 = t0;
            e1 = t1;
        end
        if (n > 0) events_due.push_back(e0);
        if (n > 1) events_due.push_back(e1);
        bytes_sent++;
    endtask

    task automatic drain_events();
        cap.valid <= 1'b0;
        do @(posedge i_clk); while (events_due.size() != 0);
    endtask

    task automatic add_row(input logic [7:0] b, input int n, input t_event e0, input t_event e1);
        t_row r;
        r.cap_byte = b;
        r.typed_n  = n;
        r.e0       = e0;
        r.e1       = e1;
        directed_rows.push_back(r);
    endtask

    function automatic logic [3:0] rand_symbol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72) return {1'b1, 3'($urandom_range(0, 7))};
        if (r < 82) return SYM_START;
        if (r < 90) return SYM_STOP;
        if (r < 93) return SYM_NONE;
        return 4'($urandom_range(SYM_NOISE_LO, SYM_NOISE_HI));
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
                     act_v);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_event e;
        if (i_rst_n === 1'b1 && evt.valid === 1'b1 && evt.ready === 1'b1) begin
            events_seen++;
            if (events_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected event, expected none, actual kind %0d value %0h",
                         $realtime, evt.event_kind, evt.value);
            end else begin
                e = events_due.pop_front();
                check_field("event_kind", e.event_kind, evt.event_kind);
                check_field("value", e.value, evt.value);
                check_field("read_flag", e.read_flag, evt.read_flag);
                check_field("acked", e.acked, evt.acked);
                check_field("last", e.last, evt.last);
                if (e.event_kind <= KIND_DATA) kind_seen[e.event_kind]++;
            end
        end
    end

    initial begin
        int idle_tab[NUM_PHASES];
        int stall_tab[NUM_PHASES];
        logic [7:0] b;
        idle_tab  = '{0, 51, 0, 21, 0};
        stall_tab = '{0, 0, 51, 21, 0};
        armed = 1'b0;
        nbits = '0;
        shreg = '0;
        i_rst_n          = 1'b0;
        cap.valid        = 1'b0;
        cap.capture_byte = '0;
        evt.ready        = 1'b0;

        add_row(8'h00, 0, NO_EVENT, NO_EVENT);
        add_row(8'h37, 0, NO_EVENT, NO_EVENT);
        add_row(8'h12, 1, mk_event(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b1), NO_EVENT);
        add_row(8'hFF, 0, NO_EVENT, NO_EVENT);
        add_row(8'hF0, 1, mk_event(KIND_START, 8'h7F, 1'b1, 1'b0, 1'b1), NO_EVENT);
        add_row(8'h88, 0, NO_EVENT, NO_EVENT);
        add_row(8'h80, 1, mk_event(KIND_DATA, 8'h00, 1'b0, 1'b1, 1'b1), NO_EVENT);
        add_row(8'h22, 2, mk_event(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b0),
                mk_event(KIND_STOP, 8'h00, 1'b0, 1'b0, 1'b1));
        add_row(8'h11, 0, NO_EVENT, NO_EVENT);
        add_row(8'hA9, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hC2, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h9B, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h2D, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h8F, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hE4, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h56, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h1A, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h3B, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hC0, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h7E, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hD2, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hFF, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hF1, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'h9A, PREDICT, NO_EVENT, NO_EVENT);
        add_row(8'hB6, PREDICT, NO_EVENT, NO_EVENT);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].cap_byte, directed_rows[i].typed_n,
                      directed_rows[i].e0, directed_rows[i].e1);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_events();
            sender_idle_pct = idle_tab[ph];
            stall_pct       = stall_tab[ph];
            if (ph == NUM_PHASES - 1) hold_reqs++;
            for (int k = 0; k < ITEMS_PHASE; k++) begin
                if (ph == 1 && k == ITEMS_PHASE / 2) drain_events();
                if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(0, 255));
                else b = {rand_symbol(), rand_symbol()};
                send_byte(b, PREDICT, NO_EVENT, NO_EVENT);
            end
        end

        drain_events();
        repeat (20) @(posedge i_clk);
        if (events_due.size() != 0) begin
            errors++;
            $display("%0t: %0d expected events never arrived", $realtime, events_due.size());
        end

        $display("Sent %0d capture bytes over %0d idle/stall phases incl. a long output hold.",
                 bytes_sent, NUM_PHASES);
        $display("Checked %0d events: %0d stop, %0d start, %0d data; %0d errors.",
                 events_seen, kind_seen[KIND_STOP], kind_seen[KIND_START],
                 kind_seen[KIND_DATA], errors);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
src/i2ccap_pkg.sv
src/i2ccap_in_if.sv
src/i2ccap_out_if.sv
src/i2ccap_decode.sv
src/i2ccap_event_queue.sv
src/i2c_capture_symbol_decoder_unit.sv
tb/testbench.sv
